### hw/rtl/assert_macros.svh
// Assertion macros shared by the scancode decoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SCS1A_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SCS1A_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/scs1a_pkg.sv
// Package for the set 1 scancode decoder: scancode constants, types and
// the character table. Depends on nothing.
`timescale 1ns / 1ps

package scs1a_pkg;

    localparam int unsigned ROM_SIZE   = 59;
    localparam int unsigned ADDR_W     = 7;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned ARROW_W    = 3;

    localparam logic [7:0] CODE_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] CODE_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] CODE_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] CODE_EXT_PREFIX   = 8'hE0;
    localparam logic [7:0] CODE_EXT_UP       = 8'h48;
    localparam logic [7:0] CODE_EXT_DOWN     = 8'h50;
    localparam logic [7:0] CODE_EXT_LEFT     = 8'h4B;
    localparam logic [7:0] CODE_EXT_RIGHT    = 8'h4D;

    typedef enum logic [ARROW_W-1:0] {
        ARROW_NONE  = 3'd0,
        ARROW_UP    = 3'd1,
        ARROW_DOWN  = 3'd2,
        ARROW_LEFT  = 3'd3,
        ARROW_RIGHT = 3'd4
    } arrow_t;

    // Decode outcome of one byte, handed from the decoder to the output stage.
    typedef struct packed {
        logic   use_rom;
        arrow_t arrow;
    } dec_t;

    // Character table: index is the make code, shift picks the upper row.
    function automatic logic [CHAR_W-1:0] key_char(input logic shift,
                                                   input logic [5:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            6'd2:  c = shift ? 7'h21 : 7'h31;
            6'd3:  c = shift ? 7'h40 : 7'h32;
            6'd4:  c = shift ? 7'h23 : 7'h33;
            6'd5:  c = shift ? 7'h24 : 7'h34;
            6'd6:  c = shift ? 7'h25 : 7'h35;
            6'd7:  c = shift ? 7'h5E : 7'h36;
            6'd8:  c = shift ? 7'h26 : 7'h37;
            6'd9:  c = shift ? 7'h2A : 7'h38;
            6'd10: c = shift ? 7'h28 : 7'h39;
            6'd11: c = shift ? 7'h29 : 7'h30;
            6'd12: c = shift ? 7'h5F : 7'h2D;
            6'd13: c = shift ? 7'h2B : 7'h3D;
            6'd14: c = 7'h08;
            6'd15: c = 7'h09;
            6'd16: c = shift ? 7'h51 : 7'h71;
            6'd17: c = shift ? 7'h57 : 7'h77;
            6'd18: c = shift ? 7'h45 : 7'h65;
            6'd19: c = shift ? 7'h52 : 7'h72;
            6'd20: c = shift ? 7'h54 : 7'h74;
            6'd21: c = shift ? 7'h59 : 7'h79;
            6'd22: c = shift ? 7'h55 : 7'h75;
            6'd23: c = shift ? 7'h49 : 7'h69;
            6'd24: c = shift ? 7'h4F : 7'h6F;
            6'd25: c = shift ? 7'h50 : 7'h70;
            6'd26: c = shift ? 7'h7B : 7'h5B;
            6'd27: c = shift ? 7'h7D : 7'h5D;
            6'd28: c = 7'h0A;
            6'd30: c = shift ? 7'h41 : 7'h61;
            6'd31: c = shift ? 7'h53 : 7'h73;
            6'd32: c = shift ? 7'h44 : 7'h64;
            6'd33: c = shift ? 7'h46 : 7'h66;
            6'd34: c = shift ? 7'h47 : 7'h67;
            6'd35: c = shift ? 7'h48 : 7'h68;
            6'd36: c = shift ? 7'h4A : 7'h6A;
            6'd37: c = shift ? 7'h4B : 7'h6B;
            6'd38: c = shift ? 7'h4C : 7'h6C;
            6'd39: c = shift ? 7'h3A : 7'h3B;
            6'd40: c = shift ? 7'h22 : 7'h27;
            6'd41: c = shift ? 7'h7E : 7'h60;
            6'd43: c = shift ? 7'h7C : 7'h5C;
            6'd44: c = shift ? 7'h5A : 7'h7A;
            6'd45: c = shift ? 7'h58 : 7'h78;
            6'd46: c = shift ? 7'h43 : 7'h63;
            6'd47: c = shift ? 7'h56 : 7'h76;
            6'd48: c = shift ? 7'h42 : 7'h62;
            6'd49: c = shift ? 7'h4E : 7'h6E;
            6'd50: c = shift ? 7'h4D : 7'h6D;
            6'd51: c = shift ? 7'h3C : 7'h2C;
            6'd52: c = shift ? 7'h3E : 7'h2E;
            6'd53: c = shift ? 7'h3F : 7'h2F;
            6'd55: c = 7'h2A;
            6'd57: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/scs1a_key_rom.sv
// Character ROM with a registered read port.
// Depends on scs1a_pkg for the table and its widths.
`timescale 1ns / 1ps

module scs1a_key_rom (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [scs1a_pkg::ADDR_W-1:0] rd_addr,
    output logic [scs1a_pkg::CHAR_W-1:0] rd_data
);
    import scs1a_pkg::*;

    logic [CHAR_W-1:0] rd_data_reg;

    // Address bit 6 selects the shifted row; the data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= key_char(rd_addr[ADDR_W-1], rd_addr[5:0]);
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/scs1a_decode.sv
// Byte classifier: holds the shift and prefix flags and forms the ROM address.
// Depends on scs1a_pkg for scancode constants and the dec_t type.
`timescale 1ns / 1ps

module scs1a_decode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [7:0]                   scan_byte,
    output scs1a_pkg::dec_t              dec,
    output logic [scs1a_pkg::ADDR_W-1:0] rom_addr
);
    import scs1a_pkg::*;

    logic shift_held_reg, shift_held_next;
    logic prefix_pending_reg, prefix_pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_held_reg     <= 1'b0;
            prefix_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            shift_held_reg     <= shift_held_next;
            prefix_pending_reg <= prefix_pending_next;
        end
    end

    always_comb
    begin
        shift_held_next     = shift_held_reg;
        prefix_pending_next = prefix_pending_reg;
        dec.use_rom         = 1'b0;
        dec.arrow           = ARROW_NONE;
        if (prefix_pending_reg)
        begin
            // The byte after the prefix is always consumed as an extended code.
            prefix_pending_next = 1'b0;
            if (!scan_byte[7])
            begin
                case (scan_byte)
                    CODE_EXT_UP:    dec.arrow = ARROW_UP;
                    CODE_EXT_DOWN:  dec.arrow = ARROW_DOWN;
                    CODE_EXT_LEFT:  dec.arrow = ARROW_LEFT;
                    CODE_EXT_RIGHT: dec.arrow = ARROW_RIGHT;
                    default:        dec.arrow = ARROW_NONE;
                endcase
            end
        end
        else if (scan_byte == CODE_LSHIFT_MAKE || scan_byte == CODE_RSHIFT_MAKE)
        begin
            shift_held_next = 1'b1;
        end
        else if (scan_byte == CODE_LSHIFT_BREAK || scan_byte == CODE_RSHIFT_BREAK)
        begin
            shift_held_next = 1'b0;
        end
        else if (scan_byte == CODE_EXT_PREFIX)
        begin
            prefix_pending_next = 1'b1;
        end
        else if (!scan_byte[7] && scan_byte < 8'(ROM_SIZE))
        begin
            dec.use_rom = 1'b1;
        end
    end

    // Codes below the table size never have bit 6 set, so six bits index a row.
    assign rom_addr = {shift_held_reg, scan_byte[5:0]};

endmodule

### hw/rtl/scancode_set1_to_ascii_decoder_core.sv
// Top level of the set 1 scancode to ASCII decoder.
// Depends on scs1a_pkg, scs1a_decode, scs1a_key_rom and assert_macros.svh.
`timescale 1ns / 1ps

// Each scancode byte beat in gives exactly one result beat out: an ASCII
// character, an arrow key, or both fields zero. The block takes one byte
// per cycle while results drain, and each result is ready in the cycle after
// its byte is accepted, from the registered read port of the character ROM;
// the result register doubles as the output stage, so a new byte is taken in
// the same cycle that a waiting result leaves. The shift and extended prefix
// flags update as each byte is accepted, so the next byte sees them at once.
// There is no reset sweep: the block is ready right after reset.
module scancode_set1_to_ascii_decoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          scan_valid,
    output logic                          scan_ready,
    input  logic [7:0]                    scan_byte,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [scs1a_pkg::CHAR_W-1:0]  char_code,
    output logic [scs1a_pkg::ARROW_W-1:0] arrow_key
);
    import scs1a_pkg::*;

    `include "assert_macros.svh"

    logic                 accept;
    dec_t                 dec;
    logic [ADDR_W-1:0]    rom_addr;
    logic [CHAR_W-1:0]    rom_data;
    logic                 out_valid_reg, out_valid_next;
    dec_t                 out_dec_reg;

    // A byte is taken whenever the result register is empty or draining.
    assign scan_ready = !out_valid_reg || result_ready;
    assign accept     = scan_valid && scan_ready;

    scs1a_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .scan_byte (scan_byte),
        .dec       (dec),
        .rom_addr  (rom_addr)
    );

    // The ROM read is enabled only on accept, so its data holds during a stall.
    scs1a_key_rom u_rom (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The decode outcome is registered alongside the ROM read, so the two stay aligned.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_dec_reg <= dec;
        end
    end

    assign result_valid = out_valid_reg;
    assign char_code    = out_dec_reg.use_rom ? rom_data : '0;
    assign arrow_key    = out_dec_reg.arrow;

    // Every accepted byte must leave a result waiting in the next cycle.
    `SCS1A_ASSERT(a_accept_gives_result, clk, rst_n,
        accept |=> out_valid_reg,
        "accepted byte gave no result")
    // A result is a character or an arrow, never both.
    `SCS1A_ASSERT(a_char_xor_arrow, clk, rst_n,
        (out_valid_reg && char_code != '0) |-> (arrow_key == ARROW_NONE),
        "character and arrow in one result")
    // Arrow codes above right are never produced.
    `SCS1A_ASSERT_ALWAYS(a_arrow_range, clk,
        out_valid_reg |-> (arrow_key <= ARROW_RIGHT),
        "arrow code out of range")

endmodule
